[rtl/fir_pkg.sv]
package fir_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 24;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned CFG_W    = 6;

  localparam logic [OUT_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_WRITE_COEF = 2'd0,
    OP_PUSH       = 2'd1,
    OP_CLEAR      = 2'd2
  } op_e;

  typedef enum logic {
    REG_TAP_COUNT = 1'b0,
    REG_OUT_SHIFT = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]                 operation;
    logic signed [SAMPLE_W-1:0] sample;
    logic [4:0]                 coef_index;
    logic signed [COEF_W-1:0]   coef_value;
  } in_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    saturated;
  } out_rsp_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic coef_we;
    logic mul;
    logic sum;
  } cell_ctrl_t;

endpackage

[rtl/fir_cell.sv]
module fir_cell
  import fir_pkg::*;
#(
  parameter int unsigned Idx  = 0,
  parameter int unsigned AccW = 45
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cell_ctrl_t                 ctrl_i,
  input  logic [CFG_W-1:0]           tap_count_i,
  input  logic [4:0]                 coef_index_i,
  input  logic signed [COEF_W-1:0]   coef_value_i,
  input  logic signed [SAMPLE_W-1:0] hist_i,
  output logic signed [SAMPLE_W-1:0] hist_o,
  input  logic signed [AccW-1:0]     acc_i,
  output logic signed [AccW-1:0]     acc_o
);

  logic signed [SAMPLE_W-1:0] hist_q;
  logic signed [COEF_W-1:0]   coef_q;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [AccW-1:0]     acc_q;
  logic                       active;
  logic                       coef_hit;

  assign active   = (32'(tap_count_i) > Idx);
  assign coef_hit = ctrl_i.coef_we && (32'(coef_index_i) == Idx);
  assign prod_d   = active ? PROD_W'(coef_q * hist_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      coef_q <= '0;
    end else begin
      if (ctrl_i.clear) begin
        hist_q <= '0;
      end else if (ctrl_i.shift) begin
        hist_q <= hist_i;
      end
      if (coef_hit) begin
        coef_q <= coef_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.sum) begin
      acc_q <= acc_i + AccW'(prod_q);
    end
  end

  assign hist_o = hist_q;
  assign acc_o  = acc_q;

endmodule

[rtl/fir_post.sv]
module fir_post
  import fir_pkg::*;
#(
  parameter int unsigned AccW = 45
) (
  input  logic signed [AccW-1:0] acc_i,
  input  logic [4:0]             out_shift_i,
  output out_rsp_t               rsp_o
);

  logic signed [AccW-1:0] shifted;
  logic                   sat_hi;
  logic                   sat_lo;

  assign shifted = acc_i >>> out_shift_i;
  assign sat_hi  = !shifted[AccW-1] && (|shifted[AccW-2:OUT_W-1]);
  assign sat_lo  = shifted[AccW-1] && !(&shifted[AccW-2:OUT_W-1]);

  always_comb begin
    rsp_o.saturated = sat_hi || sat_lo;
    if (sat_hi) begin
      rsp_o.filtered = OUT_MAX;
    end else if (sat_lo) begin
      rsp_o.filtered = OUT_MIN;
    end else begin
      rsp_o.filtered = shifted[OUT_W-1:0];
    end
  end

endmodule

[rtl/fir_filter.sv]
// Streaming direct-form FIR filter built as a row of TAPS tap cells.
// Input channel (in_valid_i/in_ready_o/in_req_i) carries one request:
//   write coefficient, push sample or clear sample history.
// Output channel (out_valid_o/out_ready_i/out_rsp_o) carries one result per
//   pushed sample: the shifted, saturated sum and a saturation flag.
// Config port (cfg_we_i/cfg_index_i/cfg_data_i): index 0 tap count,
//   index 1 output shift; write only while no push is in flight.
// Coefficient writes and clears finish on acceptance; the filter stays idle.
// A push shifts the history in all cells, registers every tap product in the
//   next cycle, then walks a partial sum through the cell row, one cell per
//   cycle, until it reaches the last cell; the final step shifts and saturates
//   the sum into the output register. The next request is accepted only after
//   that load, and the result becomes valid in the same cycle. TAPS sets the walk's length.
// A finished result waits in the output register while new requests are
//   taken; a later push holds in its final step until that register frees.
// Reset zeroes history and coefficients, sets tap count 32 and shift 0.
module fir_filter
  import fir_pkg::*;
#(
  parameter int unsigned TAPS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_req_t          in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_rsp_t         out_rsp_o,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned AccW = PROD_W + $clog2(TAPS);
  localparam int unsigned CntW = (TAPS > 1) ? $clog2(TAPS) : 1;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CFG_W-1:0]  tap_count_q;
  logic [4:0]        out_shift_q;
  logic              out_valid_q;
  out_rsp_t          out_rsp_q;
  out_rsp_t          post_rsp;
  logic              in_fire;
  logic              out_load;
  cell_ctrl_t        ctrl;

  logic signed [SAMPLE_W-1:0] hist_w [TAPS+1];
  logic signed [AccW-1:0]     acc_w  [TAPS+1];

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_req_i.operation == OP_PUSH) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_SUM;
      ST_SUM: begin
        if (cnt_q == CntW'(TAPS - 1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    ctrl.shift   = in_fire && (in_req_i.operation == OP_PUSH);
    ctrl.clear   = in_fire && (in_req_i.operation == OP_CLEAR);
    ctrl.coef_we = in_fire && (in_req_i.operation == OP_WRITE_COEF);
    ctrl.mul     = (state_q == ST_MUL);
    ctrl.sum     = (state_q == ST_SUM);
    out_load     = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
    cnt_d        = (state_q == ST_SUM) ? cnt_q + 1'b1 : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      tap_count_q <= CFG_W'(32);
      out_shift_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_TAP_COUNT: tap_count_q <= cfg_data_i;
          REG_OUT_SHIFT: out_shift_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rsp_q <= post_rsp;
    end
  end

  assign hist_w[0] = in_req_i.sample;
  assign acc_w[0]  = '0;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    fir_cell #(
      .Idx  (k),
      .AccW (AccW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .tap_count_i  (tap_count_q),
      .coef_index_i (in_req_i.coef_index),
      .coef_value_i (in_req_i.coef_value),
      .hist_i       (hist_w[k]),
      .hist_o       (hist_w[k+1]),
      .acc_i        (acc_w[k]),
      .acc_o        (acc_w[k+1])
    );
  end

  fir_post #(
    .AccW (AccW)
  ) u_post (
    .acc_i       (acc_w[TAPS]),
    .out_shift_i (out_shift_q),
    .rsp_o       (post_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_push_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_req_i.operation == OP_PUSH) |=> (state_q == ST_MUL))
    else $error("push did not start the tap products");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (32'(cnt_q) < TAPS))
    else $error("sum counter out of range");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && state_q == ST_IDLE))
    else $error("result not presented after final step");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.saturated) |->
      (out_rsp_o.filtered == OUT_MAX || out_rsp_o.filtered == OUT_MIN))
    else $error("saturated result not at a range limit");

endmodule

[tb/fir_filter_chk.sv]
`timescale 1ns / 100ps
module fir_filter_chk
  import fir_pkg::*;
#(
  parameter int unsigned TAPS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_req_t          in_req_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_rsp_t         out_rsp_i,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);

  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483648;

  logic signed [SAMPLE_W-1:0] hist_q [TAPS];
  logic signed [COEF_W-1:0]   weight_q [TAPS];
  logic [CFG_W-1:0]           tap_cnt_q;
  logic [4:0]                 shift_q;
  out_rsp_t                   due_outputs [$];
  int                         mismatch_cnt = 0;

  function automatic out_rsp_t filter_out();
    longint      acc;
    longint      scaled;
    int unsigned n;
    out_rsp_t    rsp;
    acc = 0;
    n = (tap_cnt_q > TAPS) ? TAPS : tap_cnt_q;
    for (int k = 0; k < n; k++) begin
      acc += longint'(weight_q[k]) * longint'(hist_q[k]);
    end
    scaled = acc >>> shift_q;
    rsp.saturated = 1'b1;
    if (scaled > SUM_HI) begin
      rsp.filtered = OUT_MAX;
    end else if (scaled < SUM_LO) begin
      rsp.filtered = OUT_MIN;
    end else begin
      rsp.filtered  = 32'(scaled);
      rsp.saturated = 1'b0;
    end
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_rsp_t want;
    if (!rst_ni) begin
      for (int k = 0; k < TAPS; k++) begin
        hist_q[k]   = '0;
        weight_q[k] = '0;
      end
      tap_cnt_q = 6'd32;
      shift_q   = 5'd0;
      due_outputs.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TAP_COUNT: tap_cnt_q = cfg_data_i;
          REG_OUT_SHIFT: shift_q = cfg_data_i[4:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (due_outputs.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: result with none due: filtered=%0d saturated=%0b", $realtime,
                     out_rsp_i.filtered, out_rsp_i.saturated);
          end
        end else begin
          want = due_outputs.pop_front();
          if (out_rsp_i.filtered !== want.filtered ||
              out_rsp_i.saturated !== want.saturated) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: mismatch: filtered exp %0d got %0d, saturated exp %0b got %0b",
                       $realtime, want.filtered, out_rsp_i.filtered,
                       want.saturated, out_rsp_i.saturated);
            end
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        case (in_req_i.operation)
          OP_WRITE_COEF: begin
            if (in_req_i.coef_index < TAPS) begin
              weight_q[in_req_i.coef_index] = in_req_i.coef_value;
            end
          end
          OP_PUSH: begin
            for (int k = TAPS - 1; k > 0; k--) begin
              hist_q[k] = hist_q[k-1];
            end
            hist_q[0] = in_req_i.sample;
            due_outputs.push_back(filter_out());
          end
          OP_CLEAR: begin
            for (int k = 0; k < TAPS; k++) begin
              hist_q[k] = '0;
            end
          end
          default: ;
        endcase
      end

      pending_o <= due_outputs.size();
    end
    fail_count_o <= mismatch_cnt;
  end

endmodule

[tb/fir_filter_tb.sv]
`timescale 1ns / 100ps
module fir_filter_tb;
  import fir_pkg::*;

  localparam int unsigned TAPS            = 32;
  localparam int unsigned LIMIT_CYCLES    = 2_000_000;
  localparam int unsigned DRAIN_CYCLES    = TAPS + 8;
  localparam int unsigned PRESSURE_CYCLES = 400;
  localparam int unsigned NUM_PHASES      = 12;
  localparam int unsigned PHASE_ITEMS     = 150;
  localparam logic [1:0]  OP_UNUSED       = 2'd3;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  in_req_t          in_req      = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  out_rsp_t         out_rsp;
  logic             cfg_we      = 1'b0;
  logic             cfg_index   = REG_TAP_COUNT;
  logic [CFG_W-1:0] cfg_data    = '0;
  logic             calm        = 1'b0;
  logic             pressure_go = 1'b0;
  logic             hold_long   = 1'b0;
  int               fail_count;
  int               pending;

  fir_filter #(.TAPS(TAPS)) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  fir_filter_chk #(.TAPS(TAPS)) u_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_i   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int                         r;
    logic signed [SAMPLE_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 50) return SAMPLE_W'($urandom());
    if (r < 65) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    v = SAMPLE_W'($urandom_range(0, 127));
    return v - 16'sd64;
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef();
    int                       r;
    logic signed [COEF_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 45) return COEF_W'($urandom());
    if (r < 60) return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    v = COEF_W'($urandom_range(0, 511));
    return v - 24'sd256;
  endfunction

  function automatic in_req_t mk_req(input logic [1:0] op,
                                     input logic signed [SAMPLE_W-1:0] smp,
                                     input logic [4:0] idx,
                                     input logic signed [COEF_W-1:0] val);
    in_req_t r;
    r.operation  = op;
    r.sample     = smp;
    r.coef_index = idx;
    r.coef_value = val;
    return r;
  endfunction

  function automatic in_req_t rand_req(input logic [1:0] op);
    return mk_req(op, rand_sample(), 5'($urandom()), rand_coef());
  endfunction

  task automatic send_req(input in_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input reg_e idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : receiver
    int stall;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall = pick_gap();
      end
    end
  end

  initial begin : pressure
    wait (pressure_go);
    @(posedge clk);
    hold_long <= 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk);
    hold_long <= 1'b0;
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("fir_filter_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] tap;
    logic [CFG_W-1:0] shd;
    int               sent;
    int               loads;
    int               r;
    logic [1:0]       op;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(mk_req(OP_WRITE_COEF, 16'sh0001, 5'd0, 24'sh7FFFFF));
    send_req(mk_req(OP_WRITE_COEF, 16'sh7FFF, 5'd31, 24'sh800000));
    send_req(mk_req(OP_WRITE_COEF, 16'sh8000, 5'd15, 24'sh000001));
    send_req(mk_req(OP_PUSH, 16'sh7FFF, 5'd31, 24'sh7FFFFF));
    send_req(mk_req(OP_PUSH, 16'sh8000, 5'd0, 24'sh800000));
    send_req(mk_req(OP_PUSH, 16'sh0000, 5'd0, 24'sh000000));
    send_req(mk_req(OP_CLEAR, 16'sh7FFF, 5'd31, 24'sh7FFFFF));
    send_req(mk_req(OP_PUSH, 16'sh0001, 5'd0, 24'sh000000));
    send_req(mk_req(OP_PUSH, 16'shFFFF, 5'd31, 24'shFFFFFF));
    send_req(mk_req(OP_UNUSED, 16'sh7FFF, 5'd0, 24'sh7FFFFF));
    send_req(mk_req(OP_WRITE_COEF, 16'sh0000, 5'd1, 24'shFFFFFF));
    send_req(mk_req(OP_PUSH, 16'sh8000, 5'd0, 24'sh000000));
    send_req(mk_req(OP_CLEAR, 16'sh0000, 5'd0, 24'sh000000));
    send_req(mk_req(OP_PUSH, 16'sh0000, 5'd0, 24'sh000000));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin tap = 6'd0;  shd = 6'd0;  end
        1: begin tap = 6'd1;  shd = 6'd31; end
        2: begin tap = 6'd32; shd = 6'd0;  end
        3: begin tap = 6'd63; shd = 6'h3F; end
        4: begin tap = 6'd33; shd = 6'd12; end
        5: begin tap = 6'd32; shd = 6'd31; end
        default: begin
          tap = 6'($urandom_range(1, 32));
          shd = $urandom_range(0, 1) ? 6'($urandom()) : 6'($urandom_range(0, 16));
        end
      endcase
      write_cfg(REG_TAP_COUNT, tap);
      write_cfg(REG_OUT_SHIFT, shd);
      if (ph == 2) pressure_go <= 1'b1;
      calm <= ($urandom_range(0, 3) == 0);

      sent = 0;
      if ($urandom_range(0, 1)) begin
        for (int k = 0; k < TAPS; k++) begin
          send_req(mk_req(OP_WRITE_COEF, rand_sample(), 5'(k), rand_coef()));
          sent++;
        end
      end else begin
        loads = $urandom_range(2, 12);
        repeat (loads) begin
          send_req(rand_req(OP_WRITE_COEF));
          sent++;
        end
      end

      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 72)      op = OP_PUSH;
        else if (r < 87) op = OP_WRITE_COEF;
        else if (r < 94) op = OP_CLEAR;
        else             op = OP_UNUSED;
        send_req(rand_req(op));
        if (op != OP_UNUSED) sent++;
        if (sent % 50 == 0) calm <= ($urandom_range(0, 3) == 0);
      end
    end

    calm <= 1'b0;
    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("fir_filter_tb: PASS");
    end else begin
      $display("fir_filter_tb: FAIL");
    end
    $finish;
  end

endmodule
